[design/udiv_pkg.sv]
// Shared constants and types for the unsigned shift-subtract divider.
package udiv_pkg;

  // Width of the channel payload fields
  localparam int FIELD_W = 64;

  // Significant width of the division (8 to 64)
  localparam int DATA_WIDTH = 64;

  // Step counter width: counts 0 .. DATA_WIDTH-1
  localparam int CNT_W = $clog2(DATA_WIDTH);

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_BUSY,
    ST_DONE
  } state_t;

  // Controls broadcast to every cell of the row
  typedef struct packed {
    logic load;   // take a new operand pair
    logic shift;  // run one shift-subtract step
    logic fits;   // divisor fits this step: keep the difference
  } cell_ctl_t;

  // Sequencer outputs toward the top level
  typedef struct packed {
    logic in_ready;
    logic load;
    logic shift;
    logic capture;
    logic out_valid;
  } ctrl_t;

endpackage

[design/udiv_in_if.sv]
// Input channel: dividend and divisor with valid/ready handshake.
interface udiv_in_if;
  logic                          valid;
  logic                          ready;
  logic [udiv_pkg::FIELD_W-1:0]  dividend;
  logic [udiv_pkg::FIELD_W-1:0]  divisor;

  modport source (output valid, output dividend, output divisor, input ready);
  modport sink   (input valid, input dividend, input divisor, output ready);
endinterface

[design/udiv_out_if.sv]
// Result channel: quotient and remainder with valid/ready handshake.
interface udiv_out_if;
  logic                          valid;
  logic                          ready;
  logic [udiv_pkg::FIELD_W-1:0]  quotient;
  logic [udiv_pkg::FIELD_W-1:0]  remainder;

  modport source (output valid, output quotient, output remainder, input ready);
  modport sink   (input valid, input quotient, input remainder, output ready);
endinterface

[design/unsigned_64bit_divider_top.sv]
// Top level of the unsigned restoring divider: cell row, sequencer, output register.
// Each item is loaded, run through the 64 shift-subtract steps of the cell row, one quotient bit
// per cycle, and handed to the output register once it is free; only then is a new item taken.
// A finished result waits in the output register while the next item is taken.
// Reset (rst_n, synchronous, active low) clears the sequencer and output valid only.
module unsigned_64bit_divider_top (
  input  logic       clk,
  input  logic       rst_n,
  udiv_in_if.sink    in_ch,
  udiv_out_if.source out_ch
);

  localparam int W = udiv_pkg::DATA_WIDTH;

  udiv_pkg::ctrl_t      ctrl;
  udiv_pkg::cell_ctl_t  cell_ctl;
  logic [W-1:0]         rem_vec;
  logic [W-1:0]         quo_vec;
  logic [W-1:0]         bor_vec;
  logic                 fits;
  logic [udiv_pkg::FIELD_W-1:0] quo_out_r;
  logic [udiv_pkg::FIELD_W-1:0] rem_out_r;

  udiv_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .out_ready (out_ch.ready),
    .ctrl      (ctrl)
  );

  // Divisor fits when the bit shifted out at the top is set or no borrow leaves the row
  assign fits = rem_vec[W-1] | ~bor_vec[W-1];

  assign cell_ctl.load  = ctrl.load;
  assign cell_ctl.shift = ctrl.shift;
  assign cell_ctl.fits  = fits;

  // Row of bit cells; the dividend leaves the top of the quotient row
  // into the bottom of the remainder row, quotient bits enter at the bottom
  for (genvar i = 0; i < W; i++) begin : g_cell
    logic rem_in;
    logic quo_in;
    logic bor_in;

    if (i == 0) begin : g_lsb
      assign rem_in = quo_vec[W-1];
      assign quo_in = fits;
      assign bor_in = 1'b0;
    end else begin : g_mid
      assign rem_in = rem_vec[i-1];
      assign quo_in = quo_vec[i-1];
      assign bor_in = bor_vec[i-1];
    end

    udiv_cell u_cell (
      .clk         (clk),
      .ctl         (cell_ctl),
      .ld_dividend (in_ch.dividend[i]),
      .ld_divisor  (in_ch.divisor[i]),
      .rem_in      (rem_in),
      .quo_in      (quo_in),
      .bor_in      (bor_in),
      .rem_o       (rem_vec[i]),
      .quo_o       (quo_vec[i]),
      .bor_o       (bor_vec[i])
    );
  end

  // Hold the finished result until the sink takes it
  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      quo_out_r <= udiv_pkg::FIELD_W'(quo_vec);
      rem_out_r <= udiv_pkg::FIELD_W'(rem_vec);
    end
  end

  assign in_ch.ready      = ctrl.in_ready;
  assign out_ch.valid     = ctrl.out_valid;
  assign out_ch.quotient  = quo_out_r;
  assign out_ch.remainder = rem_out_r;

endmodule

[design/udiv_cell.sv]
// One bit slice of the divider row: remainder, quotient and divisor bits.
module udiv_cell (
  input  logic                clk,
  input  udiv_pkg::cell_ctl_t ctl,
  input  logic                ld_dividend,
  input  logic                ld_divisor,
  input  logic                rem_in,
  input  logic                quo_in,
  input  logic                bor_in,
  output logic                rem_o,
  output logic                quo_o,
  output logic                bor_o
);

  logic rem_r;
  logic quo_r;
  logic dvs_r;
  logic diff;

  // Subtract the divisor bit from the shifted-in remainder bit
  assign diff  = rem_in ^ dvs_r ^ bor_in;
  assign bor_o = (~rem_in & dvs_r) | (~(rem_in ^ dvs_r) & bor_in);

  // Load operands, or advance one step: shift left, keep difference when it fits
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      rem_r <= 1'b0;
      quo_r <= ld_dividend;
      dvs_r <= ld_divisor;
    end else if (ctl.shift) begin
      rem_r <= ctl.fits ? diff : rem_in;
      quo_r <= quo_in;
    end
  end

  assign rem_o = rem_r;
  assign quo_o = quo_r;

endmodule

[design/udiv_ctrl.sv]
// Sequencer for the divider: load, step count, result handoff.
module udiv_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            out_ready,
  output udiv_pkg::ctrl_t ctrl
);

  udiv_pkg::state_t            state_r, state_nxt;
  logic [udiv_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic                        last_step;
  logic                        slot_free;

  assign last_step = (cnt_r == udiv_pkg::CNT_W'(udiv_pkg::DATA_WIDTH - 1));
  assign slot_free = !out_valid_r || out_ready;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      udiv_pkg::ST_IDLE: if (in_valid) state_nxt = udiv_pkg::ST_BUSY;
      udiv_pkg::ST_BUSY: if (last_step) state_nxt = udiv_pkg::ST_DONE;
      udiv_pkg::ST_DONE: if (slot_free) state_nxt = udiv_pkg::ST_IDLE;
      default:           state_nxt = udiv_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    ctrl          = '0;
    ctrl.out_valid = out_valid_r;
    case (state_r)
      udiv_pkg::ST_IDLE: begin
        ctrl.in_ready = 1'b1;
        ctrl.load     = in_valid;
      end
      udiv_pkg::ST_BUSY: begin
        ctrl.shift = 1'b1;
      end
      udiv_pkg::ST_DONE: begin
        ctrl.capture = slot_free;
      end
      default: begin
        ctrl.in_ready = 1'b0;
      end
    endcase
  end

  // Step counter and output valid flag
  always_comb begin
    cnt_nxt = cnt_r;
    if (ctrl.load) begin
      cnt_nxt = '0;
    end else if (ctrl.shift) begin
      cnt_nxt = cnt_r + 1'b1;
    end

    out_valid_nxt = out_valid_r;
    if (ctrl.capture) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= udiv_pkg::ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

[tb/tb_unsigned_64bit_divider_top.sv]
// Self-checking testbench for the unsigned 64-bit restoring divider top level.
`timescale 1ns / 1ps

module tb_unsigned_64bit_divider_top;

  localparam int CLK_PERIOD  = 10;
  localparam int RESET_LEN   = 12;
  localparam int STALL_LIMIT = 3000;  // cycles with no transfer before giving up
  localparam int LONG_HOLD   = 400;   // receiver hold-off for the fill-up test
  localparam int SETTLE_LEN  = 80;    // longer than the input-to-result latency

  typedef logic [udiv_pkg::FIELD_W-1:0] word_t;

  typedef struct {
    word_t quotient;
    word_t remainder;
  } quot_rem_t;

  logic clk;
  logic rst_n;

  udiv_in_if  in_if ();
  udiv_out_if out_if ();

  unsigned_64bit_divider_top i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  quot_rem_t pending_results[$];
  int        error_count = 0;
  bit        idle_en = 1'b1;
  int        hold_requests = 0;

  // Clock
  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Bit-serial restoring division with a partial remainder one bit wider than the data
  function automatic quot_rem_t calc_quot_rem(word_t dividend, word_t divisor);
    logic [udiv_pkg::DATA_WIDTH-1:0] num;
    logic [udiv_pkg::DATA_WIDTH-1:0] den;
    logic [udiv_pkg::DATA_WIDTH-1:0] quo;
    logic [udiv_pkg::DATA_WIDTH:0]   part;
    quot_rem_t                       res;
    num  = dividend[udiv_pkg::DATA_WIDTH-1:0];
    den  = divisor[udiv_pkg::DATA_WIDTH-1:0];
    quo  = '0;
    part = '0;
    for (int i = udiv_pkg::DATA_WIDTH - 1; i >= 0; i--) begin
      part = {part[udiv_pkg::DATA_WIDTH-1:0], num[i]};
      // the bit shifted out at the top always means the divisor fits
      if (part >= {1'b0, den}) begin
        part   = part - {1'b0, den};
        quo[i] = 1'b1;
      end
    end
    res.quotient                             = '0;
    res.remainder                            = '0;
    res.quotient[udiv_pkg::DATA_WIDTH-1:0]   = quo;
    res.remainder[udiv_pkg::DATA_WIDTH-1:0]  = part[udiv_pkg::DATA_WIDTH-1:0];
    return res;
  endfunction

  // Random operand with a random number of significant bits
  function automatic word_t random_operand();
    word_t w;
    w = {$urandom, $urandom};
    if ($urandom_range(0, 1) == 0) w = w >> $urandom_range(0, udiv_pkg::FIELD_W - 1);
    return w;
  endfunction

  // Offer one operand pair, hold it until the transfer, record the expected result
  task automatic send_division(input word_t dividend, input word_t divisor);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    in_if.valid    <= 1'b1;
    in_if.dividend <= dividend;
    in_if.divisor  <= divisor;
    do @(posedge clk); while (!in_if.ready);
    pending_results.push_back(calc_quot_rem(dividend, divisor));
    @(negedge clk);
  endtask

  // Drop valid and hold until every expected result has come back
  task automatic wait_all_results();
    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    @(negedge clk);
  endtask

  // Field extremes, zero divisor, divisors with the top bit set
  task automatic test_directed();
    word_t ones;
    word_t top;
    ones = '1;
    top  = word_t'(1) << (udiv_pkg::FIELD_W - 1);
    send_division('0, 64'd1);
    send_division(ones, 64'd1);
    send_division(ones, ones);
    send_division('0, ones);
    send_division(64'd1, ones);
    send_division(ones, '0);
    send_division('0, '0);
    send_division(64'h0123_4567_89ab_cdef, '0);
    send_division(ones, top);
    send_division(ones, top | 64'd1);
    send_division(top, top | 64'd1);
    send_division(ones - 64'd1, ones);
    send_division(top, 64'd3);
    send_division(ones, 64'd2);
    send_division(64'd1000, 64'd7);
    send_division(64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa);
    send_division(64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555);
    send_division(64'd12345, 64'd12345);
    send_division(64'd12344, 64'd12345);
    send_division(64'hffff_ffff, 64'h1_0000_0000);
  endtask

  // Mixed operand classes with random idling on both sides
  task automatic test_random(input int count);
    word_t n;
    word_t d;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 9))
        0: begin
          n = random_operand();
          d = '0;
        end
        1: begin
          n = {$urandom, $urandom};
          d = random_operand() | (word_t'(1) << (udiv_pkg::FIELD_W - 1));
        end
        2: begin
          d = {$urandom, $urandom};
          n = random_operand();
        end
        3: begin
          d = random_operand();
          n = d + word_t'($urandom_range(0, 3));
        end
        default: begin
          n = ($urandom_range(0, 1) == 0) ? word_t'({$urandom, $urandom}) : random_operand();
          d = random_operand();
        end
      endcase
      send_division(n, d);
    end
  endtask

  // Hold the receiver off while items keep coming, so the block fills and stalls
  task automatic test_backpressure();
    hold_requests = hold_requests + 1;
    test_random(12);
  endtask

  // Pause the sender until the block has drained, then resume
  task automatic test_drain_pause();
    test_random(20);
    wait_all_results();
    test_random(20);
    wait_all_results();
  endtask

  // Back-to-back traffic with no idling on either side
  task automatic test_streaming();
    idle_en = 1'b0;
    test_random(60);
  endtask

  // Receiver: random stall bursts, plus long hold-offs on request
  initial begin
    int stall_left;
    int hold_left;
    int holds_served;
    stall_left   = 0;
    hold_left    = 0;
    holds_served = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (holds_served != hold_requests) begin
        holds_served = holds_served + 1;
        hold_left    = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left    = hold_left - 1;
        out_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left   = stall_left - 1;
        out_if.ready <= 1'b0;
      end else if (idle_en && $urandom_range(0, 4) == 0) begin
        stall_left   = $urandom_range(1, 5) - 1;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // Compare each result transfer against the oldest expectation
  always @(posedge clk) begin
    quot_rem_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, quotient %h, remainder %h",
                 $time, out_if.quotient, out_if.remainder);
        error_count = error_count + 1;
      end else begin
        want = pending_results.pop_front();
        if (out_if.quotient !== want.quotient) begin
          $display("%0t: quotient mismatch, expected %h, actual %h",
                   $time, want.quotient, out_if.quotient);
          error_count = error_count + 1;
        end
        if (out_if.remainder !== want.remainder) begin
          $display("%0t: remainder mismatch, expected %h, actual %h",
                   $time, want.remainder, out_if.remainder);
          error_count = error_count + 1;
        end
      end
    end
  end

  // Watchdog: give up after too long without any transfer
  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    forever begin
      @(posedge clk);
      if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles = quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: timeout, %0d results still expected", $time, pending_results.size());
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // Main sequence
  initial begin
    rst_n          <= 1'b0;
    in_if.valid    <= 1'b0;
    in_if.dividend <= '0;
    in_if.divisor  <= '0;
    repeat (RESET_LEN) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed();
    test_random(200);
    test_backpressure();
    test_drain_pause();
    test_random(170);
    test_streaming();

    // drain, then let any stray result show up
    wait_all_results();
    repeat (SETTLE_LEN) @(posedge clk);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[files.f]
design/udiv_pkg.sv
design/udiv_in_if.sv
design/udiv_out_if.sv
design/udiv_cell.sv
design/udiv_ctrl.sv
design/unsigned_64bit_divider_top.sv
tb/tb_unsigned_64bit_divider_top.sv
